FILE: hdl/scd_pkg.sv
// Shared types and constants of the shift register chain driver.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int unsigned MAX_REGS_DEF = 4;
  localparam int unsigned BITS_PER_REG = 8;
  localparam int unsigned REG_CNT_W    = 3;
  localparam int unsigned BIT_IDX_W    = 5;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  localparam logic [REG_CNT_W-1:0] RESET_REG_COUNT = 3'd4;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_CLR     = 2'd1,
    OP_OE      = 2'd2,
    OP_REFRESH = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    CMD_NOP     = 3'd0,
    CMD_SET     = 3'd1,
    CMD_CLR     = 3'd2,
    CMD_OE      = 3'd3,
    CMD_REFRESH = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [BIT_IDX_W-1:0] bit_index;
    logic                 enable;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_SHIFT = 2'd1,
    BK_LATCH = 2'd2
  } back_state_e;

endpackage

FILE: hdl/scd_front.sv
// Front end: register count, request decode and command queue.
`timescale 1ns / 1ps

module scd_front #(
  parameter int unsigned MAX_REGS = scd_pkg::MAX_REGS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     operation_i,
  input  logic [scd_pkg::BIT_IDX_W-1:0]  bit_index_i,
  input  logic                           enable_value_i,
  input  logic                           cfg_we_i,
  input  logic [scd_pkg::REG_CNT_W-1:0]  cfg_wdata_i,
  output logic [scd_pkg::REG_CNT_W-1:0]  eff_count_o,
  output scd_pkg::q_head_t               head_o,
  input  logic                           pop_i
);

  logic [scd_pkg::REG_CNT_W-1:0]   reg_count_q;
  logic [scd_pkg::REG_CNT_W-1:0]   eff_count;
  logic                            in_range;
  scd_pkg::cmd_t                   cmd;
  scd_pkg::cmd_t                   q_mem_q [scd_pkg::QUEUE_DEPTH];
  logic [scd_pkg::QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [scd_pkg::QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [scd_pkg::QUEUE_CNT_W-1:0] count_q, count_d;
  logic                            push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reg_count_q <= scd_pkg::RESET_REG_COUNT;
    end else if (cfg_we_i) begin
      reg_count_q <= cfg_wdata_i;
    end
  end

  // Saturate the count to the chain length that was built.
  assign eff_count = (reg_count_q > scd_pkg::REG_CNT_W'(MAX_REGS))
                     ? scd_pkg::REG_CNT_W'(MAX_REGS) : reg_count_q;
  assign eff_count_o = eff_count;

  assign in_range = {1'b0, bit_index_i} < {eff_count, 3'b000};

  always_comb begin
    cmd.bit_index = bit_index_i;
    cmd.enable    = enable_value_i;
    unique case (scd_pkg::op_e'(operation_i))
      scd_pkg::OP_SET:     cmd.kind = in_range ? scd_pkg::CMD_SET : scd_pkg::CMD_NOP;
      scd_pkg::OP_CLR:     cmd.kind = in_range ? scd_pkg::CMD_CLR : scd_pkg::CMD_NOP;
      scd_pkg::OP_OE:      cmd.kind = scd_pkg::CMD_OE;
      scd_pkg::OP_REFRESH: cmd.kind = scd_pkg::CMD_REFRESH;
      default:             cmd.kind = scd_pkg::CMD_NOP;
    endcase
  end

  assign in_stall_o = (count_q == scd_pkg::QUEUE_CNT_W'(scd_pkg::QUEUE_DEPTH));
  assign push       = in_valid_i && !in_stall_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == scd_pkg::QUEUE_PTR_W'(scd_pkg::QUEUE_DEPTH - 1))
                 ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == scd_pkg::QUEUE_PTR_W'(scd_pkg::QUEUE_DEPTH - 1))
                 ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_ptr_q] <= cmd;
    end
  end

  assign head_o.valid = (count_q != '0);
  assign head_o.cmd   = q_mem_q[rd_ptr_q];

endmodule

FILE: hdl/scd_back.sv
// Back end: output image, enable level, shift sequencer and result register.
`timescale 1ns / 1ps

module scd_back #(
  parameter int unsigned MAX_REGS = scd_pkg::MAX_REGS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scd_pkg::q_head_t              head_i,
  output logic                          pop_o,
  input  logic [scd_pkg::REG_CNT_W-1:0] eff_count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ser_level_o,
  output logic                          shift_pulse_o,
  output logic                          latch_pulse_o,
  output logic                          oe_n_o,
  output logic                          last_o
);

  localparam int unsigned ByteW = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;

  scd_pkg::back_state_e state_q, state_d;
  logic [scd_pkg::BITS_PER_REG-1:0] image_q [MAX_REGS];
  logic                 oe_q;
  logic [ByteW-1:0]     byte_q;
  logic [2:0]           bit_q;
  logic [ByteW-1:0]     wr_byte;
  logic                 out_free;
  logic                 start_run;
  logic                 load_shift;
  logic                 load_latch;
  logic                 run_end;
  logic                 out_valid_q;
  logic                 ser_q, shift_q, latch_q, oe_out_q, last_q;

  assign out_free = !out_valid_q || !out_stall_i;
  assign run_end  = (bit_q == 3'd0) && (byte_q == '0);
  assign wr_byte  = ByteW'(head_i.cmd.bit_index >> 3);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      scd_pkg::BK_IDLE: begin
        if (head_i.valid && head_i.cmd.kind == scd_pkg::CMD_REFRESH) begin
          state_d = (eff_count_i == '0) ? scd_pkg::BK_LATCH : scd_pkg::BK_SHIFT;
        end
      end
      scd_pkg::BK_SHIFT: begin
        if (out_free && run_end) begin
          state_d = scd_pkg::BK_LATCH;
        end
      end
      scd_pkg::BK_LATCH: begin
        if (out_free) begin
          state_d = scd_pkg::BK_IDLE;
        end
      end
      default: state_d = scd_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o      = (state_q == scd_pkg::BK_IDLE) && head_i.valid;
    start_run  = pop_o && (head_i.cmd.kind == scd_pkg::CMD_REFRESH);
    load_shift = (state_q == scd_pkg::BK_SHIFT) && out_free;
    load_latch = (state_q == scd_pkg::BK_LATCH) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= scd_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(MAX_REGS); i++) begin
        image_q[i] <= '0;
      end
      oe_q <= 1'b1;
    end else if (pop_o) begin
      unique case (head_i.cmd.kind)
        scd_pkg::CMD_SET: image_q[wr_byte][head_i.cmd.bit_index[2:0]] <= 1'b1;
        scd_pkg::CMD_CLR: image_q[wr_byte][head_i.cmd.bit_index[2:0]] <= 1'b0;
        scd_pkg::CMD_OE:  oe_q <= !head_i.cmd.enable;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_run) begin
      byte_q <= ByteW'(eff_count_i - 3'd1);
      bit_q  <= 3'd7;
    end else if (load_shift) begin
      if (bit_q == 3'd0) begin
        bit_q  <= 3'd7;
        byte_q <= byte_q - 1'b1;
      end else begin
        bit_q <= bit_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_shift || load_latch) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_shift) begin
      ser_q    <= image_q[byte_q][bit_q];
      shift_q  <= 1'b1;
      latch_q  <= 1'b0;
      oe_out_q <= oe_q;
      last_q   <= 1'b0;
    end else if (load_latch) begin
      ser_q    <= 1'b0;
      shift_q  <= 1'b0;
      latch_q  <= 1'b1;
      oe_out_q <= oe_q;
      last_q   <= 1'b1;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign ser_level_o   = ser_q;
  assign shift_pulse_o = shift_q;
  assign latch_pulse_o = latch_q;
  assign oe_n_o        = oe_out_q;
  assign last_o        = last_q;

  a_no_pop_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != scd_pkg::BK_IDLE) |-> !pop_o)
    else $error("queue popped during a refresh run");

  a_latch_loads_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_latch |=> (out_valid_q && last_q && latch_q && !shift_q))
    else $error("latch step did not produce the closing result");

  a_shift_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_shift |=> (out_valid_q && shift_q && !last_q))
    else $error("shift step produced a bad result");

  a_run_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == scd_pkg::BK_SHIFT) |-> (int'(byte_q) < int'(MAX_REGS)))
    else $error("byte counter left the chain");

endmodule

FILE: hdl/shift_register_chain_driver_unit.sv
// Top level of the shift register chain driver.
`timescale 1ns / 1ps

// Drives a daisy chain of 8-bit serial-in, latched-out shift registers.
// Input channel (in_valid_i / in_stall_o): one request per accepted edge,
// carrying operation_i, bit_index_i and enable_value_i. Set, clear and
// enable requests change the image or the enable level and give no result.
// A refresh request gives 8*N shift results (highest byte first, MSB first)
// and one closing latch result flagged with last_o, N being the saturated
// register count.
// Output channel (out_valid_o / out_stall_i): one result per accepted edge.
// A request sits in a two-entry queue; the back end takes it from the
// queue head once idle. On a refresh the state register moves to shift,
// then the result register loads the first result; results follow one
// per cycle while the receiver does not stall, paced by the shift
// sequencer. A receiver stall holds the result register and the sequencer;
// the queue keeps accepting until it fills, then in_stall_o rises.
// Reset clears the image, sets the enable level to disabled (oe_n high),
// empties the queue and sets the register count to four.
// cfg_we_i / cfg_wdata_i write the register count; write it only when idle.

module shift_register_chain_driver_unit #(
  parameter int unsigned MAX_REGS = scd_pkg::MAX_REGS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic [scd_pkg::BIT_IDX_W-1:0] bit_index_i,
  input  logic                          enable_value_i,
  input  logic                          cfg_we_i,
  input  logic [scd_pkg::REG_CNT_W-1:0] cfg_wdata_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          ser_level_o,
  output logic                          shift_pulse_o,
  output logic                          latch_pulse_o,
  output logic                          oe_n_o,
  output logic                          last_o
);

  scd_pkg::q_head_t              head;
  logic                          pop;
  logic [scd_pkg::REG_CNT_W-1:0] eff_count;

  // Decode requests and queue them.
  scd_front #(
    .MAX_REGS (MAX_REGS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .bit_index_i    (bit_index_i),
    .enable_value_i (enable_value_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .eff_count_o    (eff_count),
    .head_o         (head),
    .pop_i          (pop)
  );

  // Apply queued requests and stream refresh results.
  scd_back #(
    .MAX_REGS (MAX_REGS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .eff_count_i   (eff_count),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .ser_level_o   (ser_level_o),
    .shift_pulse_o (shift_pulse_o),
    .latch_pulse_o (latch_pulse_o),
    .oe_n_o        (oe_n_o),
    .last_o        (last_o)
  );

endmodule
